@@ hw/rtl/tccg_pkg.sv @@
package tccg_pkg;

  localparam int CUR_W   = 13;
  localparam int COORD_W = 12;
  localparam int COLOR_W = 32;
  localparam int CHAR_W  = 8;
  localparam int VALUE_W = 64;

  // input modes
  localparam logic [2:0] MODE_PUTC        = 3'd0;
  localparam logic [2:0] MODE_CLEAR       = 3'd1;
  localparam logic [2:0] MODE_SETCUR      = 3'd2;
  localparam logic [2:0] MODE_HEX_FULL    = 3'd3;
  localparam logic [2:0] MODE_HEX_COMPACT = 3'd4;

  // configuration register indexes
  localparam logic REG_SCREEN_W = 1'b0;
  localparam logic REG_SCREEN_H = 1'b1;

  localparam logic [CHAR_W-1:0] CH_NL   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BS   = 8'h08;
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_X    = 8'h78;

  localparam logic [COLOR_W-1:0] COLOR_WHITE = 32'hFFFF_FFFF;
  localparam logic [COLOR_W-1:0] COLOR_BLACK = 32'h0000_0000;

  localparam logic [3:0] LAST_NIBBLE = 4'd15;

  typedef enum logic [2:0] {
    CMD_DRAW  = 3'd0,
    CMD_FILL  = 3'd1,
    CMD_COPY  = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_DONE  = 3'd4
  } cmd_kind_t;

  typedef enum logic [1:0] {
    OP_PUTC,
    OP_CLEAR,
    OP_SETCUR,
    OP_DONE
  } op_kind_t;

  typedef struct packed {
    op_kind_t             kind;
    logic [CHAR_W-1:0]    ch;
    logic [COLOR_W-1:0]   color;
    logic [COORD_W-1:0]   px;
    logic [COORD_W-1:0]   py;
  } op_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [CUR_W-1:0]     x;
    logic [CUR_W-1:0]     y;
    logic [CUR_W-1:0]     rect_w;
    logic [CUR_W-1:0]     rect_h;
    logic [COORD_W-1:0]   src_y;
    logic [COLOR_W-1:0]   paint;
    logic [CHAR_W-1:0]    glyph;
    logic                 last;
  } res_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_OP,
    F_HEX0,
    F_HEXX,
    F_DIG,
    F_TAIL,
    F_DONE
  } front_state_t;

  typedef enum logic [1:0] {
    B_RUN,
    B_COPY,
    B_FILL
  } back_state_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
    if (d < 4'd10) begin
      return CH_ZERO + {4'h0, d};
    end else begin
      return 8'h37 + {4'h0, d};
    end
  endfunction

endpackage

@@ hw/rtl/text_console_command_generator_core.sv @@
// Glyph console command generator. Each input word is one console operation
// (put character, clear, set cursor, full or compact 64-bit hex print); it is
// turned into framebuffer command words (draw glyph, fill, copy, clear) and
// always ends with a done word that carries the cursor and has tlast set.
// The front sequencer issues at most one operation per cycle into a four-entry
// queue while it is not full (a hex print is 0x, up to sixteen digits and, in
// full mode, a newline; compact mode pushes nothing for a skipped leading zero
// and prints a single 0 for a zero value), and accepts a new input word only
// once the previous one is fully queued. The back end drives at most one command
// word per cycle from its output register while the receiver is ready; an item
// gives up to four result words for a character and 57 for hex.
// screen_width and screen_height may be written only while the block is idle.
module text_console_command_generator_core
  import tccg_pkg::*;
#(
  parameter int GLYPH_W = 8,
  parameter int GLYPH_H = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [127:0]  in_tdata,   // character, color, pos_x, pos_y, value
  input  logic [2:0]    in_tuser,   // mode
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [103:0]  out_tdata,  // x, y, rect_width, rect_height, source_y, paint, glyph
  output logic [2:0]    out_tuser,  // kind
  output logic          out_tlast,
  input  logic          cfg_wr_en,
  input  logic          cfg_addr,
  input  logic [12:0]   cfg_wdata
);

  logic [CUR_W-1:0] screen_w_r, screen_h_r;
  logic             op_push, op_full, op_pop, op_empty;
  op_t              op_q_in, op_q_out;
  res_t             res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_w_r <= 13'd1024;
      screen_h_r <= 13'd768;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_SCREEN_W: screen_w_r <= cfg_wdata;
        REG_SCREEN_H: screen_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tccg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_mode  (in_tuser),
    .in_char  (in_tdata[7:0]),
    .in_color (in_tdata[39:8]),
    .in_pos_x (in_tdata[51:40]),
    .in_pos_y (in_tdata[63:52]),
    .in_value (in_tdata[127:64]),
    .op_push  (op_push),
    .op_out   (op_q_in),
    .op_full  (op_full)
  );

  tccg_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (op_push),
    .push_data (op_q_in),
    .full      (op_full),
    .pop       (op_pop),
    .pop_data  (op_q_out),
    .empty     (op_empty)
  );

  tccg_back #(
    .GLYPH_W (GLYPH_W),
    .GLYPH_H (GLYPH_H)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (!op_empty),
    .op_in     (op_q_out),
    .op_pop    (op_pop),
    .screen_w  (screen_w_r),
    .screen_h  (screen_h_r),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_out   (res)
  );

  assign out_tuser = res.kind;
  assign out_tlast = res.last;
  assign out_tdata = {res.glyph, res.paint, res.src_y, res.rect_h, res.rect_w, res.y, res.x};

endmodule

@@ hw/rtl/tccg_front.sv @@
module tccg_front
  import tccg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_mode,
  input  logic [CHAR_W-1:0]   in_char,
  input  logic [COLOR_W-1:0]  in_color,
  input  logic [COORD_W-1:0]  in_pos_x,
  input  logic [COORD_W-1:0]  in_pos_y,
  input  logic [VALUE_W-1:0]  in_value,
  output logic                op_push,
  output op_t                 op_out,
  input  logic                op_full
);

  front_state_t         state_r, state_nxt;
  logic [2:0]           mode_r;
  logic [CHAR_W-1:0]    ch_r;
  logic [COLOR_W-1:0]   color_r;
  logic [COORD_W-1:0]   px_r, py_r;
  logic [VALUE_W-1:0]   val_r, val_nxt;
  logic [3:0]           cnt_r, cnt_nxt;
  logic                 started_r, started_nxt;
  logic [3:0]           digit;
  logic                 skip;
  logic                 take;

  assign digit    = val_r[VALUE_W-1 -: 4];
  assign skip     = !started_r && (digit == 4'd0);
  assign in_ready = (state_r == F_IDLE);
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      started_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      started_r <= started_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (take) begin
      mode_r  <= in_mode;
      ch_r    <= in_char;
      color_r <= in_color;
      px_r    <= in_pos_x;
      py_r    <= in_pos_y;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    val_nxt     = val_r;
    cnt_nxt     = cnt_r;
    started_nxt = started_r;
    op_push     = 1'b0;
    op_out      = '0;
    op_out.kind = OP_DONE;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          val_nxt     = in_value;
          cnt_nxt     = LAST_NIBBLE;
          started_nxt = (in_mode != MODE_HEX_COMPACT);
          case (in_mode)
            MODE_PUTC, MODE_CLEAR, MODE_SETCUR: state_nxt = F_OP;
            MODE_HEX_FULL, MODE_HEX_COMPACT:    state_nxt = F_HEX0;
            default:                            state_nxt = F_DONE;
          endcase
        end
      end
      F_OP: begin
        op_out.ch    = ch_r;
        op_out.color = color_r;
        op_out.px    = px_r;
        op_out.py    = py_r;
        case (mode_r)
          MODE_PUTC:  op_out.kind = OP_PUTC;
          MODE_CLEAR: op_out.kind = OP_CLEAR;
          default:    op_out.kind = OP_SETCUR;
        endcase
        op_push = !op_full;
        if (!op_full) begin
          state_nxt = F_DONE;
        end
      end
      F_HEX0: begin
        op_out.kind  = OP_PUTC;
        op_out.ch    = CH_ZERO;
        op_out.color = COLOR_WHITE;
        op_push      = !op_full;
        if (!op_full) begin
          state_nxt = F_HEXX;
        end
      end
      F_HEXX: begin
        op_out.kind  = OP_PUTC;
        op_out.ch    = CH_X;
        op_out.color = COLOR_WHITE;
        op_push      = !op_full;
        if (!op_full) begin
          state_nxt = F_DIG;
        end
      end
      F_DIG: begin
        op_out.kind  = OP_PUTC;
        op_out.ch    = hex_char(digit);
        op_out.color = COLOR_WHITE;
        op_push      = !skip && !op_full;
        if (skip || !op_full) begin
          if (!skip) begin
            started_nxt = 1'b1;
          end
          val_nxt = val_r << 4;
          cnt_nxt = cnt_r - 4'd1;
          if (cnt_r == 4'd0) begin
            state_nxt = F_TAIL;
          end
        end
      end
      F_TAIL: begin
        op_out.kind  = OP_PUTC;
        op_out.color = COLOR_WHITE;
        if (mode_r == MODE_HEX_FULL) begin
          op_out.ch = CH_NL;
          op_push   = !op_full;
          if (!op_full) begin
            state_nxt = F_DONE;
          end
        end else if (!started_r) begin
          op_out.ch = CH_ZERO;
          op_push   = !op_full;
          if (!op_full) begin
            state_nxt = F_DONE;
          end
        end else begin
          state_nxt = F_DONE;
        end
      end
      F_DONE: begin
        op_out.kind = OP_DONE;
        op_push     = !op_full;
        if (!op_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/tccg_fifo.sv @@
module tccg_fifo
  import tccg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_data,
  output logic full,
  input  logic pop,
  output op_t  pop_data,
  output logic empty
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  op_t           mem_r [DEPTH];
  logic [AW-1:0] wptr_r, rptr_r;
  logic [AW:0]   count_r;
  logic          do_push, do_pop;

  assign full     = (count_r == (AW+1)'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + AW'(1);
      end
      if (do_pop) begin
        rptr_r <= rptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

@@ hw/rtl/tccg_back.sv @@
module tccg_back
  import tccg_pkg::*;
#(
  parameter int GLYPH_W = 8,
  parameter int GLYPH_H = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             op_valid,
  input  op_t              op_in,
  output logic             op_pop,
  input  logic [CUR_W-1:0] screen_w,
  input  logic [CUR_W-1:0] screen_h,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res_out
);

  localparam logic [CUR_W-1:0]   GW13 = CUR_W'(GLYPH_W);
  localparam logic [CUR_W-1:0]   GH13 = CUR_W'(GLYPH_H);
  localparam logic [COORD_W-1:0] GH12 = COORD_W'(GLYPH_H);

  back_state_t       state_r, state_nxt;
  logic [CUR_W-1:0]  cx_r, cx_nxt, cy_r, cy_nxt;
  logic              out_valid_r;
  res_t              res_r, res_nxt;
  logic              load;
  logic              out_free;
  logic [CUR_W:0]    nx, ny;
  logic              wrap, scroll;
  logic [CUR_W-1:0]  bottom, cx_bs;
  res_t              copy_res, fill_res;

  assign out_free = !out_valid_r || res_ready;
  assign nx       = {1'b0, cx_r} + (CUR_W+1)'(GLYPH_W);
  assign ny       = {1'b0, cy_r} + (CUR_W+1)'(GLYPH_H);
  assign wrap     = ({1'b0, nx} + (CUR_W+2)'(GLYPH_W)) > {2'b00, screen_w};
  assign scroll   = ({1'b0, ny} + (CUR_W+2)'(GLYPH_H)) > {2'b00, screen_h};
  assign bottom   = (screen_h > GH13) ? (screen_h - GH13) : '0;
  assign cx_bs    = (cx_r > GW13) ? (cx_r - GW13) : '0;

  always_comb begin
    copy_res        = '0;
    copy_res.kind   = CMD_COPY;
    copy_res.rect_w = screen_w;
    copy_res.rect_h = bottom;
    copy_res.src_y  = GH12;
    fill_res        = '0;
    fill_res.kind   = CMD_FILL;
    fill_res.y      = bottom;
    fill_res.rect_w = screen_w;
    fill_res.rect_h = GH13;
    fill_res.paint  = COLOR_BLACK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_RUN;
      cx_r        <= '0;
      cy_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    load      = 1'b0;
    op_pop    = 1'b0;
    res_nxt   = '0;
    case (state_r)
      B_RUN: begin
        if (op_valid && out_free) begin
          op_pop = 1'b1;
          case (op_in.kind)
            OP_PUTC: begin
              if (op_in.ch == CH_NL) begin
                cx_nxt = '0;
                if (scroll) begin
                  cy_nxt    = bottom;
                  load      = 1'b1;
                  res_nxt   = copy_res;
                  state_nxt = B_FILL;
                end else begin
                  cy_nxt = ny[CUR_W-1:0];
                end
              end else if (op_in.ch == CH_BS) begin
                if (cx_r != '0) begin
                  cx_nxt         = cx_bs;
                  load           = 1'b1;
                  res_nxt.kind   = CMD_FILL;
                  res_nxt.x      = cx_bs;
                  res_nxt.y      = cy_r;
                  res_nxt.rect_w = GW13;
                  res_nxt.rect_h = GH13;
                  res_nxt.paint  = op_in.color;
                end
              end else begin
                load          = 1'b1;
                res_nxt.kind  = CMD_DRAW;
                res_nxt.x     = cx_r;
                res_nxt.y     = cy_r;
                res_nxt.paint = op_in.color;
                res_nxt.glyph = op_in.ch;
                cx_nxt        = nx[CUR_W-1:0];
                if (wrap) begin
                  cx_nxt = '0;
                  if (scroll) begin
                    cy_nxt    = bottom;
                    state_nxt = B_COPY;
                  end else begin
                    cy_nxt = ny[CUR_W-1:0];
                  end
                end
              end
            end
            OP_CLEAR: begin
              load          = 1'b1;
              res_nxt.kind  = CMD_CLEAR;
              res_nxt.paint = op_in.color;
              cx_nxt        = '0;
              cy_nxt        = '0;
            end
            OP_SETCUR: begin
              cx_nxt = {1'b0, op_in.px};
              cy_nxt = {1'b0, op_in.py};
            end
            OP_DONE: begin
              load         = 1'b1;
              res_nxt.kind = CMD_DONE;
              res_nxt.x    = cx_r;
              res_nxt.y    = cy_r;
              res_nxt.last = 1'b1;
            end
            default: ;
          endcase
        end
      end
      B_COPY: begin
        if (out_free) begin
          load      = 1'b1;
          res_nxt   = copy_res;
          state_nxt = B_FILL;
        end
      end
      B_FILL: begin
        if (out_free) begin
          load      = 1'b1;
          res_nxt   = fill_res;
          state_nxt = B_RUN;
        end
      end
      default: state_nxt = B_RUN;
    endcase
  end

  assign res_valid = out_valid_r;
  assign res_out   = res_r;

endmodule

@@ bench/tb_text_console_command_generator_core.sv @@
`timescale 1ns / 1ps

module tb_text_console_command_generator_core;
  import tccg_pkg::*;

  localparam int GLYPH_W = 8;
  localparam int GLYPH_H = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_PAUSE = 40;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  typedef struct {
    cmd_kind_t    kind;
    logic [12:0]  x;
    logic [12:0]  y;
    logic [12:0]  rect_w;
    logic [12:0]  rect_h;
    logic [11:0]  src_y;
    logic [31:0]  paint;
    logic [7:0]   glyph;
    logic         last;
  } cmd_word_t;

  logic          clk;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  logic [127:0]  in_tdata;   // character, color, pos_x, pos_y, value
  logic [2:0]    in_tuser;   // mode
  logic          out_tvalid;
  logic          out_tready;
  logic [103:0]  out_tdata;  // x, y, rect_width, rect_height, source_y, paint, glyph
  logic [2:0]    out_tuser;  // kind
  logic          out_tlast;
  logic          cfg_wr_en;
  logic          cfg_addr;
  logic [12:0]   cfg_wdata;

  cmd_word_t     pending_cmds[$];
  logic [12:0]   cur_x;
  logic [12:0]   cur_y;
  int unsigned   scr_w;
  int unsigned   scr_h;
  int            mismatch_count;
  int            send_idle_pct;
  int            recv_stall_pct;
  int            holdoff_left;
  int            cycle_count;

  text_console_command_generator_core #(
    .GLYPH_W(GLYPH_W),
    .GLYPH_H(GLYPH_H)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // console cursor and command prediction
  function automatic void queue_cmd(cmd_kind_t kind, int unsigned x, int unsigned y,
                                    int unsigned w, int unsigned h, int unsigned sy,
                                    logic [31:0] paint, logic [7:0] glyph, logic last);
    cmd_word_t c;
    c.kind   = kind;
    c.x      = x[12:0];
    c.y      = y[12:0];
    c.rect_w = w[12:0];
    c.rect_h = h[12:0];
    c.src_y  = sy[11:0];
    c.paint  = paint;
    c.glyph  = glyph;
    c.last   = last;
    pending_cmds.push_back(c);
  endfunction

  function automatic void line_feed();
    int unsigned ny;
    int unsigned bottom;
    ny = cur_y + GLYPH_H;
    cur_x = '0;
    if (ny + GLYPH_H > scr_h) begin
      bottom = (scr_h > GLYPH_H) ? scr_h - GLYPH_H : 0;
      queue_cmd(CMD_COPY, 0, 0, scr_w, bottom, GLYPH_H, COLOR_BLACK, 8'h00, 1'b0);
      queue_cmd(CMD_FILL, 0, bottom, scr_w, GLYPH_H, 0, COLOR_BLACK, 8'h00, 1'b0);
      cur_y = bottom[12:0];
    end else begin
      cur_y = ny[12:0];
    end
  endfunction

  function automatic void put_glyph(logic [7:0] c, logic [31:0] color);
    int unsigned nx;
    if (c == CH_NL) begin
      line_feed();
    end else if (c == CH_BS) begin
      if (cur_x != 0) begin
        cur_x = (cur_x > GLYPH_W) ? 13'(cur_x - GLYPH_W) : '0;
        queue_cmd(CMD_FILL, cur_x, cur_y, GLYPH_W, GLYPH_H, 0, color, 8'h00, 1'b0);
      end
    end else begin
      queue_cmd(CMD_DRAW, cur_x, cur_y, 0, 0, 0, color, c, 1'b0);
      nx = cur_x + GLYPH_W;
      cur_x = nx[12:0];
      if (nx + GLYPH_W > scr_w) line_feed();
    end
  endfunction

  function automatic logic [7:0] digit_char(logic [3:0] d);
    if (d < 4'd10) return CH_ZERO + {4'h0, d};
    return CH_UPPER_A + {4'h0, d} - 8'd10;
  endfunction

  function automatic void print_value(logic [63:0] value, logic compact);
    logic started;
    logic [3:0] nib;
    started = !compact;
    put_glyph(CH_ZERO, COLOR_WHITE);
    put_glyph(CH_X, COLOR_WHITE);
    for (int i = 15; i >= 0; i--) begin
      nib = value[i*4 +: 4];
      if (started || nib != 0) begin
        started = 1'b1;
        put_glyph(digit_char(nib), COLOR_WHITE);
      end
    end
    if (compact) begin
      if (!started) put_glyph(CH_ZERO, COLOR_WHITE);
    end else begin
      put_glyph(CH_NL, COLOR_WHITE);
    end
  endfunction

  function automatic void plan_commands(logic [2:0] mode, logic [7:0] ch, logic [31:0] color,
                                        logic [11:0] px, logic [11:0] py,
                                        logic [63:0] value);
    case (mode)
      MODE_PUTC: begin
        put_glyph(ch, color);
      end
      MODE_CLEAR: begin
        queue_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, color, 8'h00, 1'b0);
        cur_x = '0;
        cur_y = '0;
      end
      MODE_SETCUR: begin
        cur_x = {1'b0, px};
        cur_y = {1'b0, py};
      end
      MODE_HEX_FULL: begin
        print_value(value, 1'b0);
      end
      MODE_HEX_COMPACT: begin
        print_value(value, 1'b1);
      end
      default: begin
      end
    endcase
    queue_cmd(CMD_DONE, cur_x, cur_y, 0, 0, 0, COLOR_BLACK, 8'h00, 1'b1);
  endfunction

  // result checking
  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h actual %0h", field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    cmd_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_cmds.size() == 0) begin
        $error("unexpected word: kind %0d tdata %0h", out_tuser, out_tdata);
        mismatch_count++;
      end else begin
        want = pending_cmds.pop_front();
        check_field("kind", want.kind, out_tuser);
        check_field("x", want.x, out_tdata[12:0]);
        check_field("y", want.y, out_tdata[25:13]);
        check_field("rect_width", want.rect_w, out_tdata[38:26]);
        check_field("rect_height", want.rect_h, out_tdata[51:39]);
        check_field("source_y", want.src_y, out_tdata[63:52]);
        check_field("paint", want.paint, out_tdata[95:64]);
        check_field("glyph", want.glyph, out_tdata[103:96]);
        check_field("last", want.last, out_tlast);
      end
    end
  end

  // receiver side
  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      out_tready = 1'b0;
      holdoff_left--;
    end else begin
      out_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_op(logic [2:0] mode, logic [7:0] ch, logic [31:0] color,
                         logic [11:0] px, logic [11:0] py, logic [63:0] value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tuser  = mode;
    in_tdata  = {value, py, px, color, ch};
    in_tvalid = 1'b1;
    plan_commands(mode, ch, color, px, py, value);
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic settle_block();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(logic addr, int unsigned val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = val[12:0];
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (addr == REG_SCREEN_W) scr_w = val & 32'h1FFF;
    else scr_h = val & 32'h1FFF;
  endtask

  task automatic put_char(logic [7:0] ch, logic [31:0] color);
    send_op(MODE_PUTC, ch, color, 12'($urandom), 12'($urandom), {$urandom, $urandom});
  endtask

  task automatic set_cursor(logic [11:0] px, logic [11:0] py);
    send_op(MODE_SETCUR, 8'($urandom), $urandom, px, py, {$urandom, $urandom});
  endtask

  task automatic print_hex(logic [2:0] mode, logic [63:0] value);
    send_op(mode, 8'($urandom), $urandom, 12'($urandom), 12'($urandom), value);
  endtask

  task automatic test_put_char();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    put_char("A", COLOR_BLACK);
    put_char(8'hFF, COLOR_WHITE);
    put_char(8'h00, $urandom);
    put_char(CH_BS, $urandom);
    put_char(CH_NL, $urandom);
    put_char(CH_BS, $urandom);
    set_cursor(12'd3, 12'd32);
    put_char(CH_BS, $urandom);
  endtask

  task automatic test_cursor_ops();
    send_idle_pct  = 26;
    recv_stall_pct = 26;
    set_cursor(12'd4095, 12'd4095);
    put_char("z", $urandom);
    set_cursor(12'd1016, 12'd752);
    put_char("q", $urandom);
    send_op(MODE_CLEAR, 8'($urandom), $urandom, 12'($urandom), 12'($urandom),
            {$urandom, $urandom});
    send_op(3'd5, 8'($urandom), $urandom, 12'($urandom), 12'($urandom),
            {$urandom, $urandom});
    send_op(3'd7, 8'($urandom), $urandom, 12'($urandom), 12'($urandom),
            {$urandom, $urandom});
  endtask

  task automatic test_hex_print();
    print_hex(MODE_HEX_FULL, 64'h0);
    print_hex(MODE_HEX_FULL, 64'hFFFF_FFFF_FFFF_FFFF);
    print_hex(MODE_HEX_COMPACT, 64'h0);
    print_hex(MODE_HEX_COMPACT, 64'h1);
    print_hex(MODE_HEX_COMPACT, 64'hFFFF_FFFF_FFFF_FFFF);
    print_hex(MODE_HEX_COMPACT, 64'h0123_4567_89AB_CDEF);
  endtask

  task automatic test_screen_extremes();
    settle_block();
    write_reg(REG_SCREEN_W, 1);
    write_reg(REG_SCREEN_H, 1);
    put_char("m", $urandom);
    put_char(CH_NL, $urandom);
    print_hex(MODE_HEX_COMPACT, 64'hA);
    settle_block();
    write_reg(REG_SCREEN_W, 4096);
    write_reg(REG_SCREEN_H, 4096);
    set_cursor(12'd4095, 12'd4095);
    put_char("w", $urandom);
    put_char(CH_NL, $urandom);
    settle_block();
    write_reg(REG_SCREEN_W, 40);
    write_reg(REG_SCREEN_H, 20);
    repeat (4) put_char("k", $urandom);
  endtask

  task automatic send_random_op();
    int r;
    int unsigned span_x;
    int unsigned span_y;
    logic [2:0] mode;
    logic [7:0] ch;
    logic [31:0] color;
    logic [11:0] px;
    logic [11:0] py;
    logic [63:0] value;
    r = $urandom_range(99);
    mode  = MODE_PUTC;
    ch    = 8'($urandom);
    color = $urandom;
    px    = 12'($urandom);
    py    = 12'($urandom);
    value = {$urandom, $urandom} >> $urandom_range(0, 63);
    span_x = (scr_w > 4095) ? 4095 : scr_w;
    span_y = (scr_h > 4095) ? 4095 : scr_h;
    if (r < 45) begin
      ch = 8'($urandom_range(32, 126));
    end else if (r < 53) begin
      ch = CH_NL;
    end else if (r < 60) begin
      ch = CH_BS;
    end else if (r < 65) begin
    end else if (r < 75) begin
      mode = MODE_HEX_FULL;
      if (r < 68) value = {$urandom, $urandom};
    end else if (r < 86) begin
      mode = MODE_HEX_COMPACT;
      if (r < 77) value = '0;
    end else if (r < 94) begin
      mode = MODE_SETCUR;
      if (r < 91) begin
        px = 12'($urandom_range(0, span_x));
        py = 12'($urandom_range(0, span_y));
      end
    end else if (r < 97) begin
      mode = MODE_CLEAR;
    end else begin
      mode = 3'($urandom_range(5, 7));
    end
    send_op(mode, ch, color, px, py, value);
  endtask

  task automatic test_random_traffic();
    int idle_in[4];
    int stall_out[4];
    int unsigned w;
    int unsigned h;
    idle_in   = '{0, 57, 0, 26};
    stall_out = '{0, 0, 57, 26};
    for (int p = 0; p < 4; p++) begin
      settle_block();
      case ($urandom_range(3))
        0: begin
          w = ($urandom_range(1)) ? 1 : 4096;
          h = ($urandom_range(1)) ? 1 : 4096;
        end
        1: begin
          w = 1024;
          h = 768;
        end
        default: begin
          w = $urandom_range(1, 160);
          h = $urandom_range(1, 160);
        end
      endcase
      write_reg(REG_SCREEN_W, w);
      write_reg(REG_SCREEN_H, h);
      send_idle_pct  = idle_in[p];
      recv_stall_pct = stall_out[p];
      repeat (45) send_random_op();
    end
  endtask

  task automatic test_output_holdoff();
    settle_block();
    write_reg(REG_SCREEN_W, 64);
    write_reg(REG_SCREEN_H, 48);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_left   = 400;
    repeat (4) put_char(8'($urandom_range(32, 126)), $urandom);
    print_hex(MODE_HEX_FULL, {$urandom, $urandom});
    put_char(CH_NL, $urandom);
    repeat (4) put_char(8'($urandom_range(32, 126)), $urandom);
    put_char(CH_BS, $urandom);
    print_hex(MODE_HEX_COMPACT, {$urandom, $urandom});
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    out_tready     = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_addr       = REG_SCREEN_W;
    cfg_wdata      = '0;
    cur_x          = '0;
    cur_y          = '0;
    scr_w          = 1024;
    scr_h          = 768;
    mismatch_count = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_left   = 0;
    cycle_count    = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_put_char();
    test_cursor_ops();
    test_hex_print();
    test_screen_extremes();
    test_random_traffic();
    test_output_holdoff();
    settle_block();

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ text_console_command_generator_core.f @@
hw/rtl/tccg_pkg.sv
hw/rtl/tccg_front.sv
hw/rtl/tccg_fifo.sv
hw/rtl/tccg_back.sv
hw/rtl/text_console_command_generator_core.sv
bench/tb_text_console_command_generator_core.sv
